@@ sv/rrf_pkg.sv @@
`timescale 1ns / 1ps
// rrf_pkg: shared types and constants for the rotating register file core
// holds the item kinds, request/response structs and csr indexes; no dependencies

package rrf_pkg;

   // width of each configuration register
   localparam int CFG_W   = 5;
   localparam int CFG_MAX = (2 ** CFG_W) - 1;

   localparam int ADDR_W = 8;
   localparam int DATA_W = 32;

   typedef logic [CFG_W-1:0] cfg_word_type;

   // csr index width and register indexes
   localparam int CSR_IDX_W = 1;
   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_ACTIVE_SIZE    = 1'b0;
   localparam csr_index_type CSR_ROTATING_COUNT = 1'b1;

   // configuration reset values
   localparam cfg_word_type ACTIVE_SIZE_RESET    = 5'd4;
   localparam cfg_word_type ROTATING_COUNT_RESET = 5'd0;

   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_TICK  = 2'd2,
      KIND_CLEAR = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic [ADDR_W-1:0]       address;
      logic [DATA_W-1:0]       write_data;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0]       read_data;
      logic                    out_of_range;
   } rsp_type;

endpackage

@@ sv/rotating_register_file_core.sv @@
`timescale 1ns / 1ps
// rotating_register_file_core: register file with a rotating low region
// depends on rrf_pkg for the item structs, kinds and csr indexes

// One item (read, write, next-iteration tick or clear) is taken in every
// cycle: busy is always low, so start alone decides when an item goes in.
// Each item gives exactly one result, shown on rsp_data with rsp_strobe
// high for a single cycle starting at the edge after the one that took the
// item.
// The latency is set by the input register and the registered read port
// of the word store; the receiver cannot stall and must take every result.
// Writes and ticks take effect for the very next item, with no hazard.
// The store comes out of reset (and out of a clear item) reading as zero at
// once: per-word valid bits are all cleared together, no clearing pass.
// The user must write configuration (active size, rotating count) through
// the csr port while no item is in flight; the block does not enforce it;
// a write leaving the offset at or above the new rotating count zeroes it.

module rotating_register_file_core #(
   parameter int MAX_REGS = 16
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   start,
   output logic                   busy,
   input  rrf_pkg::req_type       req_data,

   output logic                   rsp_strobe,
   output rrf_pkg::rsp_type       rsp_data,

   input  logic                   csr_write_enable,
   input  rrf_pkg::csr_index_type csr_index,
   input  rrf_pkg::cfg_word_type  csr_write_data
);

   // largest effective size: store depth, capped by what the csr can hold
   localparam int SIZE_CAP_INT = (MAX_REGS > rrf_pkg::CFG_MAX) ? rrf_pkg::CFG_MAX
                                                               : MAX_REGS;
   localparam rrf_pkg::cfg_word_type SIZE_CAP = rrf_pkg::cfg_word_type'(SIZE_CAP_INT);
   // offset is always below the effective count, or zero when that count is zero
   localparam int OFS_W = (SIZE_CAP_INT > 1) ? $clog2(SIZE_CAP_INT) : 1;
   localparam int IDX_W = $clog2(MAX_REGS);
   localparam int SUM_W = rrf_pkg::CFG_W + 1;

   // configuration and rotation state
   rrf_pkg::cfg_word_type active_size_ff, active_size_in;
   rrf_pkg::cfg_word_type rotating_count_ff, rotating_count_in;
   logic [OFS_W-1:0]      offset_ff, offset_in;

   // input register
   logic                  s1_valid_ff;
   rrf_pkg::req_type      s1_req_ff;

   // word store and its valid bits
   logic [rrf_pkg::DATA_W-1:0] store_mem [MAX_REGS];
   logic [MAX_REGS-1:0]        valid_ff, valid_in;

   // result register
   logic                       rsp_strobe_ff;
   logic                       rsp_err_ff;
   logic                       rsp_keep_ff;
   logic [rrf_pkg::DATA_W-1:0] rd_data_ff;

   // stage-one decode
   rrf_pkg::cfg_word_type eff_size;
   rrf_pkg::cfg_word_type eff_count;
   logic                  is_access;
   logic                  addr_err;
   logic                  in_rot;
   logic [SUM_W-1:0]      rot_sum;
   logic [SUM_W-1:0]      rot_pos;
   logic [IDX_W-1:0]      word_idx;
   logic                  do_write;
   logic                  do_read;
   rrf_pkg::cfg_word_type ofs_inc;
   logic [OFS_W-1:0]      tick_offset;

   // csr side: effective count of the values being written
   rrf_pkg::cfg_word_type new_count;

   function automatic rrf_pkg::cfg_word_type clamp_size(input rrf_pkg::cfg_word_type size);
      clamp_size = (size > SIZE_CAP) ? SIZE_CAP : size;
   endfunction

   function automatic rrf_pkg::cfg_word_type clamp_count(input rrf_pkg::cfg_word_type size,
                                                         input rrf_pkg::cfg_word_type count);
      rrf_pkg::cfg_word_type s;
      s = clamp_size(size);
      clamp_count = (count > s) ? s : count;
   endfunction

   // one item every cycle
   assign busy = 1'b0;

   // ------------------------------------------------------------------
   // configuration writes
   // ------------------------------------------------------------------
   always_comb begin
      active_size_in    = active_size_ff;
      rotating_count_in = rotating_count_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            rrf_pkg::CSR_ACTIVE_SIZE:    active_size_in    = csr_write_data;
            rrf_pkg::CSR_ROTATING_COUNT: rotating_count_in = csr_write_data;
            default: ;
         endcase
      end
      new_count = clamp_count(active_size_in, rotating_count_in);
   end

   // ------------------------------------------------------------------
   // stage one: address check, rotation map, offset update
   // ------------------------------------------------------------------
   always_comb begin
      eff_size  = clamp_size(active_size_ff);
      eff_count = clamp_count(active_size_ff, rotating_count_ff);

      is_access = (s1_req_ff.kind == rrf_pkg::KIND_READ) ||
                  (s1_req_ff.kind == rrf_pkg::KIND_WRITE);
      addr_err  = s1_req_ff.address >= rrf_pkg::ADDR_W'(eff_size);

      // address and offset are both below the count: one compare and subtract
      in_rot  = s1_req_ff.address < rrf_pkg::ADDR_W'(eff_count);
      rot_sum = SUM_W'(s1_req_ff.address[rrf_pkg::CFG_W-1:0]) + SUM_W'(offset_ff);
      if (rot_sum >= SUM_W'(eff_count)) begin
         rot_pos = rot_sum - SUM_W'(eff_count);
      end else begin
         rot_pos = rot_sum;
      end
      word_idx = in_rot ? IDX_W'(rot_pos) : IDX_W'(s1_req_ff.address);

      do_write = s1_valid_ff && (s1_req_ff.kind == rrf_pkg::KIND_WRITE) && !addr_err;
      do_read  = s1_valid_ff && (s1_req_ff.kind == rrf_pkg::KIND_READ) && !addr_err;

      // next-iteration tick wraps at the count, stays at zero with no rotation
      ofs_inc = rrf_pkg::cfg_word_type'(offset_ff) + rrf_pkg::cfg_word_type'(1);
      if ((eff_count == '0) || (ofs_inc >= eff_count)) begin
         tick_offset = '0;
      end else begin
         tick_offset = OFS_W'(ofs_inc);
      end
   end

   always_comb begin
      offset_in = offset_ff;
      valid_in  = valid_ff;
      priority if (csr_write_enable) begin
         // fold offset back if it no longer sits below the new count
         if (rrf_pkg::cfg_word_type'(offset_ff) >= new_count) begin
            offset_in = '0;
         end
      end else if (s1_valid_ff && (s1_req_ff.kind == rrf_pkg::KIND_TICK)) begin
         offset_in = tick_offset;
      end else if (s1_valid_ff && (s1_req_ff.kind == rrf_pkg::KIND_CLEAR)) begin
         offset_in = '0;
         valid_in  = '0;
      end else if (do_write) begin
         valid_in[word_idx] = 1'b1;
      end else begin
         offset_in = offset_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_size_ff    <= rrf_pkg::ACTIVE_SIZE_RESET;
         rotating_count_ff <= rrf_pkg::ROTATING_COUNT_RESET;
         offset_ff         <= '0;
         valid_ff          <= '0;
         s1_valid_ff       <= 1'b0;
         rsp_strobe_ff     <= 1'b0;
      end else begin
         active_size_ff    <= active_size_in;
         rotating_count_ff <= rotating_count_in;
         offset_ff         <= offset_in;
         valid_ff          <= valid_in;
         s1_valid_ff       <= start && !busy;
         rsp_strobe_ff     <= s1_valid_ff;
      end
   end

   // input payload register
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         s1_req_ff <= req_data;
      end
   end

   // ------------------------------------------------------------------
   // word store: one write port, one registered read port
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (do_write) begin
         store_mem[word_idx] <= s1_req_ff.write_data;
      end
      rd_data_ff <= store_mem[word_idx];
   end

   // result flags; a word never written since reset or clear reads as zero
   always_ff @(posedge clock) begin
      rsp_err_ff  <= is_access && addr_err;
      rsp_keep_ff <= do_read && valid_ff[word_idx];
   end

   assign rsp_strobe             = rsp_strobe_ff;
   assign rsp_data.read_data     = rsp_keep_ff ? rd_data_ff : '0;
   assign rsp_data.out_of_range  = rsp_err_ff;

   // ------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------
   a_offset_below_count: assert property (@(posedge clock) disable iff (reset)
      (offset_ff == '0) || (rrf_pkg::cfg_word_type'(offset_ff) < eff_count))
      else $error("rotation offset not below effective count");

   a_error_reads_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.out_of_range) |-> (rsp_data.read_data == '0))
      else $error("out of range result carries read data");

   a_one_result_per_item: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |=> rsp_strobe)
      else $error("item in stage one gave no result");

   a_clear_empties_store: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && (s1_req_ff.kind == rrf_pkg::KIND_CLEAR) && !csr_write_enable)
         |=> (valid_ff == '0) && (offset_ff == '0))
      else $error("clear item left words or offset behind");

endmodule
